[sv/tsi_pkg.sv]
// Shared types, constants and the one-bit division step of the torus site index unit.
// No dependencies; every other file of the unit imports this package.
package tsi_pkg;

  localparam int DATA_W         = 32;
  localparam int DIM_W          = 4;
  localparam int AXIS_W         = 3;
  localparam int MAX_DIM_DEF    = 8;
  localparam int INDEX_BITS_DEF = 32;

  typedef enum logic [1:0] {
    FN_SHIFT  = 2'd0,
    FN_DISP   = 2'd1,
    FN_RADIUS = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_AXIS   = 2'd2,
    ST_CONFIG = 2'd3
  } status_t;

  typedef enum logic {
    REG_SIDE = 1'b0,
    REG_DIM  = 1'b1
  } reg_idx_t;

  // Live configuration as seen by the datapath.
  typedef struct packed {
    logic [DATA_W-1:0] side_len;
    logic [DIM_W-1:0]  dim;
    logic              bad;
  } tsi_cfg_t;

  // Per-item control that travels with the data down the pipeline.
  typedef struct packed {
    func_t             func;
    logic [AXIS_W-1:0] axis;
    logic [DATA_W-1:0] radius;
    logic              off_neg;
    logic [DATA_W-1:0] delta;
    logic              in_reach;
    logic              oor_a;
    logic              oor_b;
  } tsi_ctl_t;

  // One restoring division step: shifts the next dividend bit into the
  // remainder and the new quotient bit into the low end of the word.
  // Returns {remainder, word}.
  function automatic logic [2*DATA_W-1:0] div_step(input logic [DATA_W-1:0] rem,
                                                  input logic [DATA_W-1:0] word,
                                                  input logic [DATA_W-1:0] dvs);
    logic [DATA_W:0] t;
    logic [DATA_W:0] dif;
    logic            ge;
    t   = {rem, word[DATA_W-1]};
    dif = t - {1'b0, dvs};
    ge  = (t >= {1'b0, dvs});
    div_step = {(ge ? dif[DATA_W-1:0] : t[DATA_W-1:0]), word[DATA_W-2:0], ge};
  endfunction

endpackage

[sv/tsi_cfg.sv]
// Configuration registers and the volume check sequencer of the torus site index unit.
// Depends on tsi_pkg.
module tsi_cfg import tsi_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata,
  output tsi_cfg_t          cfg
);

  localparam int PW = INDEX_BITS + DATA_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_CHK
  } state_t;

  state_t            state_r;
  logic [DATA_W-1:0] side_r;
  logic [DIM_W-1:0]  dim_r;
  logic [INDEX_BITS-1:0] vol_r;
  logic [PW-1:0]     prod_r;
  logic [DIM_W-1:0]  cnt_r;
  logic              ovf_r;
  logic              plain_bad;

  assign plain_bad = (side_r == '0) || (dim_r == '0) || (int'(dim_r) > MAX_DIM);

  // The volume L^D is built one multiply at a time, each through S_MUL and S_CHK; a
  // product that leaves the index range marks the configuration as unusable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      side_r  <= DATA_W'(16);
      dim_r   <= DIM_W'(2);
      ovf_r   <= 1'b0;
      cnt_r   <= '0;
      vol_r   <= INDEX_BITS'(1);
    end else if (cfg_we) begin
      if (cfg_index == REG_SIDE) begin
        side_r <= cfg_wdata;
      end else begin
        dim_r <= cfg_wdata[DIM_W-1:0];
      end
      state_r <= S_MUL;
      ovf_r   <= 1'b0;
      cnt_r   <= '0;
      vol_r   <= INDEX_BITS'(1);
    end else begin
      case (state_r)
        S_MUL: begin
          if (plain_bad || cnt_r >= dim_r) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (|prod_r[PW-1:INDEX_BITS]) begin
            ovf_r   <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            vol_r   <= prod_r[INDEX_BITS-1:0];
            cnt_r   <= cnt_r + DIM_W'(1);
            state_r <= S_MUL;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    prod_r <= PW'(vol_r) * PW'(side_r);
  end

  assign cfg.side_len = side_r;
  assign cfg.dim      = dim_r;
  assign cfg.bad      = plain_bad || ovf_r;

endmodule

[sv/tsi_axis_block.sv]
// One axis of the digit pipeline: a bit-per-stage division by L of both sites and the
// shift distance, then two stages that form this axis' result digit. Depends on tsi_pkg.
module tsi_axis_block import tsi_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int AXIS    = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tsi_cfg_t                       cfg,
  input  logic                           in_vld,
  input  tsi_ctl_t                       in_ctl,
  input  logic [DATA_W-1:0]              in_a,
  input  logic [DATA_W-1:0]              in_b,
  input  logic [DATA_W-1:0]              in_o,
  input  logic [MAX_DIM-1:0][DATA_W-1:0] in_dig,
  output logic                           out_vld,
  output tsi_ctl_t                       out_ctl,
  output logic [DATA_W-1:0]              out_a,
  output logic [DATA_W-1:0]              out_b,
  output logic [DATA_W-1:0]              out_o,
  output logic [MAX_DIM-1:0][DATA_W-1:0] out_dig
);

  logic [DATA_W-1:0]              vld_r;
  tsi_ctl_t                       ctl_r  [DATA_W];
  logic [DATA_W-1:0]              aw_r   [DATA_W];
  logic [DATA_W-1:0]              am_r   [DATA_W];
  logic [DATA_W-1:0]              bw_r   [DATA_W];
  logic [DATA_W-1:0]              bm_r   [DATA_W];
  logic [DATA_W-1:0]              ow_r   [DATA_W];
  logic [DATA_W-1:0]              om_r   [DATA_W];
  logic [MAX_DIM-1:0][DATA_W-1:0] dig_r  [DATA_W];

  for (genvar i = 0; i < DATA_W; i++) begin : g_div
    logic                           s_vld;
    tsi_ctl_t                       s_ctl;
    logic [DATA_W-1:0]              s_aw, s_am, s_bw, s_bm, s_ow, s_om;
    logic [MAX_DIM-1:0][DATA_W-1:0] s_dig;
    if (i == 0) begin : g_src
      assign s_vld = in_vld;
      assign s_ctl = in_ctl;
      assign s_aw  = in_a;
      assign s_am  = '0;
      assign s_bw  = in_b;
      assign s_bm  = '0;
      assign s_ow  = in_o;
      assign s_om  = '0;
      assign s_dig = in_dig;
    end else begin : g_src
      assign s_vld = vld_r[i-1];
      assign s_ctl = ctl_r[i-1];
      assign s_aw  = aw_r[i-1];
      assign s_am  = am_r[i-1];
      assign s_bw  = bw_r[i-1];
      assign s_bm  = bm_r[i-1];
      assign s_ow  = ow_r[i-1];
      assign s_om  = om_r[i-1];
      assign s_dig = dig_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= s_vld;
      end
      ctl_r[i] <= s_ctl;
      dig_r[i] <= s_dig;
      {am_r[i], aw_r[i]} <= div_step(s_am, s_aw, cfg.side_len);
      {bm_r[i], bw_r[i]} <= div_step(s_bm, s_bw, cfg.side_len);
      {om_r[i], ow_r[i]} <= div_step(s_om, s_ow, cfg.side_len);
    end
  end

  // First digit stage: the shift distance on axis zero, the displacement
  // digit and the plain distance between the two coordinates.
  logic                           x_vld_r;
  tsi_ctl_t                       x_ctl_r;
  logic [MAX_DIM-1:0][DATA_W-1:0] x_dig_r;
  logic [DATA_W-1:0]              x_oc_r, x_cd_r, x_d_r, x_aq_r, x_bq_r, x_oq_r;
  tsi_ctl_t                       x_ctl_nxt;
  logic [DATA_W-1:0]              oc, tc, orem;

  assign oc   = am_r[DATA_W-1];
  assign tc   = bm_r[DATA_W-1];
  assign orem = om_r[DATA_W-1];

  always_comb begin
    x_ctl_nxt = ctl_r[DATA_W-1];
    if (AXIS == 0) begin
      x_ctl_nxt.delta = (x_ctl_nxt.off_neg && orem != '0) ? cfg.side_len - orem : orem;
    end
    if (int'(cfg.dim) == AXIS + 1) begin
      x_ctl_nxt.oor_a = (aw_r[DATA_W-1] != '0);
      x_ctl_nxt.oor_b = (bw_r[DATA_W-1] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r <= 1'b0;
    end else begin
      x_vld_r <= vld_r[DATA_W-1];
    end
    x_ctl_r <= x_ctl_nxt;
    x_dig_r <= dig_r[DATA_W-1];
    x_oc_r  <= oc;
    x_cd_r  <= (tc >= oc) ? tc - oc : cfg.side_len - (oc - tc);
    x_d_r   <= (oc >= tc) ? oc - tc : tc - oc;
    x_aq_r  <= aw_r[DATA_W-1];
    x_bq_r  <= bw_r[DATA_W-1];
    x_oq_r  <= ow_r[DATA_W-1];
  end

  // Second digit stage: wrap the shifted coordinate, fold the periodic
  // distance and store the digit for this axis.
  logic [DATA_W:0]   sum;
  logic [DATA_W:0]   sum_wrap;
  logic [DATA_W-1:0] newc, far_d, per_d, dig_val;
  tsi_ctl_t          y_ctl_nxt;
  logic [MAX_DIM-1:0][DATA_W-1:0] y_dig_nxt;

  assign sum      = {1'b0, x_oc_r} + {1'b0, x_ctl_r.delta};
  assign sum_wrap = sum - {1'b0, cfg.side_len};
  assign newc     = (sum >= {1'b0, cfg.side_len}) ? sum_wrap[DATA_W-1:0] : sum[DATA_W-1:0];
  assign far_d    = cfg.side_len - x_d_r;
  assign per_d    = (x_d_r < far_d) ? x_d_r : far_d;

  always_comb begin
    case (x_ctl_r.func)
      FN_SHIFT: dig_val = (int'(x_ctl_r.axis) == AXIS) ? newc : x_oc_r;
      FN_DISP:  dig_val = x_cd_r;
      default:  dig_val = '0;
    endcase
    y_ctl_nxt          = x_ctl_r;
    y_ctl_nxt.in_reach = x_ctl_r.in_reach && (per_d <= x_ctl_r.radius);
    y_dig_nxt          = x_dig_r;
    y_dig_nxt[AXIS]    = dig_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= x_vld_r;
    end
    out_ctl <= y_ctl_nxt;
    out_dig <= y_dig_nxt;
    out_a   <= x_aq_r;
    out_b   <= x_bq_r;
    out_o   <= x_oq_r;
  end

endmodule

[sv/tsi_repack.sv]
// Horner repacking of the result digits into a flat index, one axis per stage,
// highest axis first. Depends on tsi_pkg.
module tsi_repack import tsi_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [DATA_W-1:0]              side_len,
  input  logic                           in_vld,
  input  tsi_ctl_t                       in_ctl,
  input  logic [MAX_DIM-1:0][DATA_W-1:0] in_dig,
  output logic                           out_vld,
  output tsi_ctl_t                       out_ctl,
  output logic [DATA_W-1:0]              out_acc
);

  logic [MAX_DIM-1:0]             vld_r;
  tsi_ctl_t                       ctl_r [MAX_DIM];
  logic [DATA_W-1:0]              acc_r [MAX_DIM];
  logic [MAX_DIM-1:0][DATA_W-1:0] dig_r [MAX_DIM];

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_stage
    logic                           s_vld;
    tsi_ctl_t                       s_ctl;
    logic [DATA_W-1:0]              s_acc;
    logic [MAX_DIM-1:0][DATA_W-1:0] s_dig;
    logic [DATA_W-1:0]              prod;
    if (j == 0) begin : g_src
      assign s_vld = in_vld;
      assign s_ctl = in_ctl;
      assign s_acc = '0;
      assign s_dig = in_dig;
    end else begin : g_src
      assign s_vld = vld_r[j-1];
      assign s_ctl = ctl_r[j-1];
      assign s_acc = acc_r[j-1];
      assign s_dig = dig_r[j-1];
    end
    // Only the low half of the product is kept, so the multiply stays at the
    // word width.
    assign prod = s_acc * side_len;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= s_vld;
      end
      ctl_r[j] <= s_ctl;
      dig_r[j] <= s_dig;
      acc_r[j] <= prod + s_dig[MAX_DIM-1-j];
    end
  end

  assign out_vld = vld_r[MAX_DIM-1];
  assign out_ctl = ctl_r[MAX_DIM-1];
  assign out_acc = acc_r[MAX_DIM-1];

endmodule

[sv/torus_site_index_unit.sv]
// Top level of the torus site index unit: ports, digit pipeline, repacking and result word.
// Depends on tsi_pkg, tsi_cfg, tsi_axis_block and tsi_repack.
//
//   channel   | ports                                   | handshake
//   ----------+-----------------------------------------+--------------------------
//   input     | in_func, in_site_a, in_site_b,          | start high, busy low
//             | in_axis_sel, in_offset, in_radius       |
//   result    | out_site_out, out_inside_res, out_status| out_valid for one cycle
//   config    | cfg_index, cfg_wdata                    | cfg_we high
//
// One input word is taken every cycle; busy is never raised. Each word gives one
// result word. The depth comes from the per-axis division by L, which retires one
// quotient bit per stage for DATA_W stages on every axis, followed by two digit
// stages per axis and one multiply-add stage per axis for repacking.
// Reset (rst_n low at a clock edge) empties the pipeline and loads L = 16, D = 2.
// The receiver cannot stall, so results leave on out_valid without holding.
// After a configuration write the volume check takes at most MAX_DIM multiplies,
// each through the S_MUL and S_CHK states, far fewer than the pipeline stages, so its
// verdict is ready before any later word reaches the result stage.
module torus_site_index_unit import tsi_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_func,
  input  logic [DATA_W-1:0]        in_site_a,
  input  logic [DATA_W-1:0]        in_site_b,
  input  logic [AXIS_W-1:0]        in_axis_sel,
  input  logic signed [DATA_W-1:0] in_offset,
  input  logic [DATA_W-1:0]        in_radius,
  output logic                     out_valid,
  output logic [DATA_W-1:0]        out_site_out,
  output logic                     out_inside_res,
  output logic [1:0]               out_status,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata
);

  tsi_cfg_t cfg;

  tsi_cfg #(
    .MAX_DIM   (MAX_DIM),
    .INDEX_BITS(INDEX_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  // The pipeline never stalls, so a word is taken whenever start is high.
  assign busy = 1'b0;

  logic [MAX_DIM:0]               bv;
  tsi_ctl_t                       bc [MAX_DIM+1];
  logic [DATA_W-1:0]              ba [MAX_DIM+1];
  logic [DATA_W-1:0]              bb [MAX_DIM+1];
  logic [DATA_W-1:0]              bo [MAX_DIM+1];
  logic [MAX_DIM-1:0][DATA_W-1:0] bd [MAX_DIM+1];

  // Entry: the shift distance goes in as a magnitude, its sign travels along
  // so that the first axis can turn the remainder into a floor modulo.
  always_comb begin
    bc[0]          = '0;
    bc[0].func     = func_t'(in_func);
    bc[0].axis     = in_axis_sel;
    bc[0].radius   = in_radius;
    bc[0].off_neg  = in_offset[DATA_W-1];
    bc[0].in_reach = 1'b1;
  end

  assign bv[0] = start && !busy;
  assign ba[0] = in_site_a;
  assign bb[0] = in_site_b;
  assign bo[0] = in_offset[DATA_W-1] ? DATA_W'(-in_offset) : DATA_W'(in_offset);
  assign bd[0] = '0;

  // Every axis, used or not, goes through its block. Above the used axes a
  // site that is in range has only zero digits, which leaves the shift and
  // displacement sums and the radius test unchanged.
  for (genvar k = 0; k < MAX_DIM; k++) begin : g_axis
    tsi_axis_block #(
      .MAX_DIM(MAX_DIM),
      .AXIS   (k)
    ) u_axis (
      .clk    (clk),
      .rst_n  (rst_n),
      .cfg    (cfg),
      .in_vld (bv[k]),
      .in_ctl (bc[k]),
      .in_a   (ba[k]),
      .in_b   (bb[k]),
      .in_o   (bo[k]),
      .in_dig (bd[k]),
      .out_vld(bv[k+1]),
      .out_ctl(bc[k+1]),
      .out_a  (ba[k+1]),
      .out_b  (bb[k+1]),
      .out_o  (bo[k+1]),
      .out_dig(bd[k+1])
    );
  end

  logic              rp_vld;
  tsi_ctl_t          rp_ctl;
  logic [DATA_W-1:0] rp_acc;

  tsi_repack #(
    .MAX_DIM(MAX_DIM)
  ) u_repack (
    .clk     (clk),
    .rst_n   (rst_n),
    .side_len(cfg.side_len),
    .in_vld  (bv[MAX_DIM]),
    .in_ctl  (bc[MAX_DIM]),
    .in_dig  (bd[MAX_DIM]),
    .out_vld (rp_vld),
    .out_ctl (rp_ctl),
    .out_acc (rp_acc)
  );

  // Result word. A bad configuration outranks a site out of range, which in
  // turn outranks a shift along an axis that is not in use. The unused
  // operation code gives an all-zero word.
  status_t           stat_nxt;
  logic [DATA_W-1:0] site_nxt;
  logic              inside_nxt;
  logic              oor;

  assign oor = rp_ctl.oor_a || (rp_ctl.func != FN_SHIFT && rp_ctl.oor_b);

  always_comb begin
    stat_nxt   = ST_OK;
    site_nxt   = '0;
    inside_nxt = 1'b0;
    if (rp_ctl.func != FN_NONE) begin
      if (cfg.bad) begin
        stat_nxt = ST_CONFIG;
      end else if (oor) begin
        stat_nxt = ST_RANGE;
      end else if (rp_ctl.func == FN_SHIFT && {1'b0, rp_ctl.axis} >= cfg.dim) begin
        stat_nxt = ST_AXIS;
      end else begin
        case (rp_ctl.func)
          FN_SHIFT:  site_nxt   = rp_acc;
          FN_DISP:   site_nxt   = rp_acc;
          FN_RADIUS: inside_nxt = rp_ctl.in_reach;
          default:   site_nxt   = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= rp_vld;
    end
    out_site_out   <= site_nxt;
    out_inside_res <= inside_nxt;
    out_status     <= stat_nxt;
  end

endmodule

[bench/site_index_checker.sv]
// Result checker for the torus site index unit: predicts each result word and compares it.
// Depends on tsi_pkg for the operation, status and register codes.
`timescale 1ns / 1ps
module site_index_checker import tsi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               in_func,
  input  logic [DATA_W-1:0]        in_site_a,
  input  logic [DATA_W-1:0]        in_site_b,
  input  logic [AXIS_W-1:0]        in_axis_sel,
  input  logic signed [DATA_W-1:0] in_offset,
  input  logic [DATA_W-1:0]        in_radius,
  input  logic                     out_valid,
  input  logic [DATA_W-1:0]        out_site_out,
  input  logic                     out_inside_res,
  input  logic [1:0]               out_status,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  output int                       fail_count,
  output int                       words_pending
);

  typedef struct packed {
    logic [DATA_W-1:0] site;
    logic              in_reach;
    status_t           status;
  } site_result_t;

  site_result_t      expected_words[$];
  logic [DATA_W-1:0] side_len;
  logic [DIM_W-1:0]  dim_count;

  // Computes the result word for one request under the current lattice shape.
  function automatic site_result_t lattice_query(input logic [1:0] fn,
                                                 input logic [DATA_W-1:0] site_a,
                                                 input logic [DATA_W-1:0] site_b,
                                                 input logic [AXIS_W-1:0] axis,
                                                 input logic signed [DATA_W-1:0] shift_by,
                                                 input logic [DATA_W-1:0] radius);
    site_result_t      res;
    longint unsigned   side, vol, stride, acc, a, b, oldc, newc, delta, mag, ca, cb, d;
    longint            soff;
    bit                good;
    res = '0;
    res.status = ST_OK;
    side = side_len;
    a = site_a;
    b = site_b;
    vol = 1;
    good = (side != 0) && (dim_count != 0) && (dim_count <= MAX_DIM_DEF);
    if (good) begin
      for (int k = 0; k < dim_count; k++) begin
        if (vol > 64'hFFFF_FFFF / side) good = 0;
        else vol = vol * side;
      end
    end
    if (func_t'(fn) == FN_NONE) return res;
    if (!good) begin
      res.status = ST_CONFIG;
    end else if (a >= vol || (func_t'(fn) != FN_SHIFT && b >= vol)) begin
      res.status = ST_RANGE;
    end else if (func_t'(fn) == FN_SHIFT) begin
      if (axis >= dim_count) begin
        res.status = ST_AXIS;
      end else begin
        stride = 1;
        for (int k = 0; k < axis; k++) stride = stride * side;
        oldc = (a / stride) % side;
        // Floor modulo: a negative distance wraps up from the far side.
        soff = shift_by;
        if (soff >= 0) begin
          delta = longint'(soff) % side;
        end else begin
          mag = (-soff) % side;
          delta = (mag == 0) ? 0 : side - mag;
        end
        newc = (oldc + delta) % side;
        res.site = DATA_W'(a - oldc * stride + newc * stride);
      end
    end else if (func_t'(fn) == FN_DISP) begin
      stride = 1;
      acc = 0;
      for (int k = 0; k < dim_count; k++) begin
        ca = a % side;
        cb = b % side;
        acc += ((cb >= ca) ? cb - ca : side - (ca - cb)) * stride;
        a = a / side;
        b = b / side;
        stride = stride * side;
      end
      res.site = DATA_W'(acc);
    end else begin
      res.in_reach = 1'b1;
      for (int k = 0; k < dim_count; k++) begin
        ca = a % side;
        cb = b % side;
        d = (ca >= cb) ? ca - cb : cb - ca;
        if (side - d < d) d = side - d;
        if (d > radius) res.in_reach = 1'b0;
        a = a / side;
        b = b / side;
      end
    end
    return res;
  endfunction

  assign words_pending = expected_words.size();

  always @(posedge clk) begin
    site_result_t want;
    if (!rst_n) begin
      expected_words.delete();
      side_len  <= 32'd16;
      dim_count <= 4'd2;
      fail_count <= 0;
    end else begin
      if (start && !busy)
        expected_words = {expected_words,
                          lattice_query(in_func, in_site_a, in_site_b,
                                        in_axis_sel, in_offset, in_radius)};
      if (cfg_we) begin
        if (reg_idx_t'(cfg_index) == REG_SIDE) side_len <= cfg_wdata;
        else dim_count <= cfg_wdata[DIM_W-1:0];
      end
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          $error("result word with none expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (want.site !== out_site_out || want.in_reach !== out_inside_res ||
              want.status !== out_status) begin
            if (want.site !== out_site_out)
              $error("site_out: expected %0h, got %0h", want.site, out_site_out);
            if (want.in_reach !== out_inside_res)
              $error("inside_res: expected %0b, got %0b", want.in_reach, out_inside_res);
            if (want.status !== out_status)
              $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[bench/testbench.sv]
// Top of the torus site index unit bench: clock, reset, stimulus and verdict.
// Depends on tsi_pkg, torus_site_index_unit and site_index_checker.
`timescale 1ns / 1ps
module testbench;
  import tsi_pkg::*;

  // Pipeline depth at the default sizes, plus some margin for draining.
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 600000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_func = '0;
  logic [DATA_W-1:0]        in_site_a = '0;
  logic [DATA_W-1:0]        in_site_b = '0;
  logic [AXIS_W-1:0]        in_axis_sel = '0;
  logic signed [DATA_W-1:0] in_offset = '0;
  logic [DATA_W-1:0]        in_radius = '0;
  logic                     out_valid;
  logic [DATA_W-1:0]        out_site_out;
  logic                     out_inside_res;
  logic [1:0]               out_status;
  logic                     cfg_we = 1'b0;
  logic                     cfg_index = 1'b0;
  logic [DATA_W-1:0]        cfg_wdata = '0;
  int                       fail_count;
  int                       words_pending;
  int                       cycle_count = 0;

  // The bench keeps its own view of the lattice shape so that random sites
  // can mostly be drawn from inside the volume.
  longint unsigned          lattice_volume = 256;
  longint unsigned          lattice_side = 16;
  bit                       allow_idle = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  torus_site_index_unit DUT (.*);

  site_index_checker checker_inst (.*);

  // Hard stop if the pipeline hangs or results go missing.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Presents one word and holds it until the unit takes it. The start flag
  // stays high afterwards so that back-to-back words need no extra edge.
  task automatic send_word(input func_t fn, input logic [DATA_W-1:0] a,
                           input logic [DATA_W-1:0] b, input logic [AXIS_W-1:0] axis,
                           input logic [DATA_W-1:0] shift_by,
                           input logic [DATA_W-1:0] radius);
    start       <= 1'b1;
    in_func     <= fn;
    in_site_a   <= a;
    in_site_b   <= b;
    in_axis_sel <= axis;
    in_offset   <= shift_by;
    in_radius   <= radius;
    do @(posedge clk); while (busy);
  endtask

  // Random idle burst on the sender side, skipped in the tail of the run.
  task automatic maybe_idle();
    int gap;
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits for every outstanding result and then for the pipeline to drain,
  // so that a register write never lands on a word in flight.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_lattice(input logic [DATA_W-1:0] side, input logic [DIM_W-1:0] dims);
    longint unsigned vol;
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SIDE;
    cfg_wdata <= side;
    @(posedge clk);
    cfg_index <= REG_DIM;
    cfg_wdata <= {{(DATA_W-DIM_W){1'b0}}, dims};
    @(posedge clk);
    cfg_we <= 1'b0;
    // Bad shapes still get stimulus; any site if L or D is 0 or L^D overflows.
    vol = 1;
    for (int k = 0; k < dims; k++) begin
      if (side != 0) vol = (vol > 64'hFFFF_FFFF) ? vol : vol * side;
    end
    lattice_side   = (side == 0) ? 1 : side;
    lattice_volume = (side == 0 || dims == 0 || vol > 64'hFFFF_FFFF) ? 64'h1_0000_0000 : vol;
  endtask

  function automatic logic [DATA_W-1:0] pick_site();
    if ($urandom_range(0, 7) == 0) return $urandom();
    if ($urandom_range(0, 9) == 0) return DATA_W'(lattice_volume - 1);
    return DATA_W'({$urandom(), $urandom()} % lattice_volume);
  endfunction

  function automatic logic [DATA_W-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return DATA_W'(lattice_side);
      3: return -DATA_W'(lattice_side) - 1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_radius();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return DATA_W'($urandom_range(0, 16) % (lattice_side / 2 + 2));
  endfunction

  task automatic random_words(input int count);
    func_t fn;
    for (int n = 0; n < count; n++) begin
      fn = func_t'($urandom_range(0, 15) == 0 ? FN_NONE : $urandom_range(0, 2));
      send_word(fn, pick_site(), pick_site(), $urandom_range(0, 7),
                pick_offset(), pick_radius());
      maybe_idle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset shape, a 16 by 16 torus.
    send_word(FN_SHIFT, 32'd17, '0, 3'd0, 32'd0, '0);
    send_word(FN_SHIFT, 32'd15, '0, 3'd0, 32'd1, '0);
    send_word(FN_SHIFT, 32'd0, '0, 3'd1, -32'sd1, '0);
    send_word(FN_SHIFT, 32'd34, '0, 3'd1, 32'd16, '0);
    send_word(FN_SHIFT, 32'd34, '0, 3'd0, -32'sd17, '0);
    send_word(FN_SHIFT, 32'd255, '0, 3'd1, 32'h7FFF_FFFF, '0);
    send_word(FN_SHIFT, 32'd255, '0, 3'd0, 32'h8000_0000, '0);
    // A bad axis, then an out-of-range site that must win over it.
    send_word(FN_SHIFT, 32'd5, '0, 3'd2, 32'd1, '0);
    send_word(FN_SHIFT, 32'd5, '0, 3'd7, 32'd1, '0);
    send_word(FN_SHIFT, 32'd256, '0, 3'd7, 32'd1, '0);
    send_word(FN_SHIFT, 32'hFFFF_FFFF, '0, 3'd0, 32'd1, '0);
    send_word(FN_DISP, 32'd0, 32'd255, 3'd0, '0, '0);
    send_word(FN_DISP, 32'd255, 32'd0, 3'd0, '0, '0);
    send_word(FN_DISP, 32'd0, 32'd256, 3'd0, '0, '0);
    send_word(FN_DISP, 32'hFFFF_FFFF, 32'd3, 3'd0, '0, '0);
    send_word(FN_RADIUS, 32'd0, 32'h88, 3'd0, '0, 32'd8);
    send_word(FN_RADIUS, 32'd0, 32'h88, 3'd0, '0, 32'd7);
    send_word(FN_RADIUS, 32'd1, 32'hF0, 3'd0, '0, 32'd0);
    send_word(FN_RADIUS, 32'd3, 32'd3, 3'd0, '0, 32'd0);
    send_word(FN_RADIUS, 32'd0, 32'hFF, 3'd0, '0, 32'hFFFF_FFFF);
    send_word(FN_RADIUS, 32'd0, 32'h100, 3'd0, '0, 32'hFFFF_FFFF);
    send_word(FN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_words(150);

    // Shapes from the degenerate to the widest index, bad ones included.
    set_lattice(32'd1, 4'd1);
    random_words(40);
    set_lattice(32'hFFFF_FFFF, 4'd1);
    random_words(80);
    set_lattice(32'd2, 4'd8);
    random_words(80);
    set_lattice(32'd3, 4'd8);
    random_words(80);
    set_lattice(32'd65535, 4'd2);
    random_words(60);
    set_lattice(32'd255, 4'd4);
    random_words(60);
    // Volume exactly 2^32 no longer fits the index.
    set_lattice(32'd65536, 4'd2);
    random_words(20);
    set_lattice(32'd0, 4'd3);
    random_words(15);
    set_lattice(32'd5, 4'd0);
    random_words(15);
    set_lattice(32'd5, 4'd9);
    random_words(10);
    set_lattice(32'd7, 4'd15);
    random_words(10);
    set_lattice(32'd6, 4'd5);
    random_words(100);

    // Tail of the run: back-to-back words with no gaps.
    allow_idle = 1'b0;
    random_words(100);
    start <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && words_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
